[hw/rtl/gn3_pkg.sv]
`timescale 1ns / 1ps

package gn3_pkg;

    // default coordinate width taken from the input fields
    localparam int COORD_WIDTH_DEF = 32;
    localparam int CORNER_COUNT    = 8;

    // gradient component, signed Q1.15 in [-32768, 32768]
    localparam int GRAD_W = 17;

    // per-corner gradient lane: hash, square root and divider steps
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 16;
    localparam int CORNER_LAT = 6 + SQRT_STEPS + 1 + DIV_STEPS + 1;

    // corner seed multipliers
    localparam logic [31:0] SEED_MUL_X = 32'd2097013;
    localparam logic [31:0] SEED_MUL_Y = 32'd2039;

    // integer hash constants
    localparam logic [31:0] HASH_MUL  = 32'd15731;
    localparam logic [31:0] HASH_ADD1 = 32'd789221;
    localparam logic [31:0] HASH_ADD2 = 32'd1376312589;
    localparam logic [31:0] HASH_BIAS = 32'd1073741824;

    // register reset values
    localparam logic [15:0] FREQ_RESET = 16'd1024;
    localparam logic [15:0] AMP_RESET  = 16'd16384;

    // register indexes
    localparam logic [7:0] REG_FREQ = 8'd0;
    localparam logic [7:0] REG_AMP  = 8'd1;

    typedef logic [GRAD_W-1:0] t_grad;
    typedef t_grad [2:0] t_grad_vec;

endpackage

[hw/rtl/gn3_corner.sv]
`timescale 1ns / 1ps

module gn3_corner import gn3_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_seed,
    output t_grad_vec   o_grad
);

    typedef logic [2:0][31:0] t_cvec;

    logic [2:0][31:0] r_v1;
    logic [2:0][31:0] r_v2;
    logic [2:0][31:0] r_vv2;
    logic [2:0][31:0] r_v3;
    logic [2:0][31:0] r_a3;
    logic [2:0][30:0] r_h4;
    t_cvec            r_c5;
    logic [2:0][60:0] r_csq5;
    t_cvec            r_c6;
    logic [61:0]      r_sum6;

    logic [61:0]      r_rem  [SQRT_STEPS];
    logic [30:0]      r_root [SQRT_STEPS];
    t_cvec            r_sc   [SQRT_STEPS];

    logic [2:0][46:0] r_pd;
    logic [2:0]       r_pneg;
    logic [30:0]      r_pn;
    logic             r_pz;

    logic [2:0][46:0] r_dd   [DIV_STEPS];
    logic [2:0][15:0] r_dq   [DIV_STEPS];
    logic [30:0]      r_dn   [DIV_STEPS];
    logic [2:0]       r_dneg [DIV_STEPS];
    logic             r_dz   [DIV_STEPS];

    t_grad_vec        r_grad;

    logic [2:0][31:0] s_seed;
    logic [2:0][31:0] s_t;
    logic signed [31:0] s_c   [3];
    logic signed [63:0] s_csq [3];
    logic [2:0][30:0] s_mag;

    // hash front: xor-shift, square, poly, final product
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_seed[i] = i_seed + 32'(i);
            s_t[i]    = r_v3[i] * r_a3[i] + HASH_ADD2;
            s_c[i]    = $signed(HASH_BIAS) - $signed({1'b0, r_h4[i]});
            s_csq[i]  = s_c[i] * s_c[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_v1[i]   <= (s_seed[i] << 13) ^ s_seed[i];
                r_v2[i]   <= r_v1[i];
                r_vv2[i]  <= r_v1[i] * r_v1[i];
                r_v3[i]   <= r_v2[i];
                r_a3[i]   <= r_vv2[i] * HASH_MUL + HASH_ADD1;
                r_h4[i]   <= s_t[i][30:0];
                r_c5[i]   <= s_c[i];
                r_csq5[i] <= s_csq[i][60:0];
            end
            r_c6   <= r_c5;
            r_sum6 <= 62'(r_csq5[0]) + 62'(r_csq5[1]) + 62'(r_csq5[2]);
        end
    end

    // square root, one root bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam int J = SQRT_STEPS - 1 - k;
        logic [61:0] rem_in;
        logic [30:0] root_in;
        t_cvec       c_in;
        logic [62:0] trial;

        if (k == 0) begin : g_first
            assign rem_in  = r_sum6;
            assign root_in = '0;
            assign c_in    = r_c6;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign c_in    = r_sc[k-1];
        end

        assign trial = ({32'b0, root_in} << (J + 1)) | (63'd1 << (2 * J));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({1'b0, rem_in} >= trial) begin
                    r_rem[k]  <= 62'({1'b0, rem_in} - trial);
                    r_root[k] <= root_in | (31'd1 << J);
                end else begin
                    r_rem[k]  <= rem_in;
                    r_root[k] <= root_in;
                end
                r_sc[k] <= c_in;
            end
        end
    end

    // divider setup: magnitude scaled by 2^15 plus half the norm for rounding
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_mag[i] = r_sc[SQRT_STEPS-1][i][31] ? 31'(-r_sc[SQRT_STEPS-1][i])
                                                 : 31'(r_sc[SQRT_STEPS-1][i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_pd[i]   <= {1'b0, s_mag[i], 15'b0} + 47'(r_root[SQRT_STEPS-1] >> 1);
                r_pneg[i] <= r_sc[SQRT_STEPS-1][i][31];
            end
            r_pn <= r_root[SQRT_STEPS-1];
            r_pz <= (r_root[SQRT_STEPS-1] == '0);
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar m = 0; m < DIV_STEPS; m++) begin : g_div
        localparam int B = DIV_STEPS - 1 - m;
        logic [2:0][46:0] d_in;
        logic [2:0][15:0] q_in;
        logic [30:0]      n_in;
        logic [2:0]       neg_in;
        logic             z_in;
        logic [46:0]      trial;

        if (m == 0) begin : g_first
            assign d_in   = r_pd;
            assign q_in   = '0;
            assign n_in   = r_pn;
            assign neg_in = r_pneg;
            assign z_in   = r_pz;
        end else begin : g_next
            assign d_in   = r_dd[m-1];
            assign q_in   = r_dq[m-1];
            assign n_in   = r_dn[m-1];
            assign neg_in = r_dneg[m-1];
            assign z_in   = r_dz[m-1];
        end

        assign trial = 47'(n_in) << B;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    if (d_in[i] >= trial) begin
                        r_dd[m][i] <= d_in[i] - trial;
                        r_dq[m][i] <= q_in[i] | (16'd1 << B);
                    end else begin
                        r_dd[m][i] <= d_in[i];
                        r_dq[m][i] <= q_in[i];
                    end
                end
                r_dn[m]   <= n_in;
                r_dneg[m] <= neg_in;
                r_dz[m]   <= z_in;
            end
        end
    end

    // sign and zero-vector handling
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_dz[DIV_STEPS-1]) begin
                    r_grad[i] <= '0;
                end else if (r_dneg[DIV_STEPS-1][i]) begin
                    r_grad[i] <= -{1'b0, r_dq[DIV_STEPS-1][i]};
                end else begin
                    r_grad[i] <= {1'b0, r_dq[DIV_STEPS-1][i]};
                end
            end
        end
    end

    assign o_grad = r_grad;

endmodule

[hw/rtl/gradient_noise_3d_scalar.sv]
`timescale 1ns / 1ps

// One-octave 3-D gradient noise on signed Q16.16 points, result in signed Q16.16.
// The block takes one point every clock cycle unless the output stalls. Most of
// the pipeline depth lies in the eight corner lanes, each of which runs a
// 31-stage square root and a 16-stage divider to normalize its hash gradient.
// An output stall while a result is valid freezes the whole pipeline and is
// passed back to the input in the same cycle. Frequency and amplitude registers
// are written through the configuration port, which is always ready; the user
// must write them only while no item is in flight; the block does not enforce it.

module gradient_noise_3d_scalar import gn3_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_noise_sample,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int DOT_W    = 35;
    localparam int LP_W     = COORD_WIDTH + 16;
    localparam int STG_G    = 3 + CORNER_LAT;
    localparam int TOTAL    = STG_G + 10;
    localparam int FW_LEN   = STG_G + 3;
    localparam int TAP_FRAC = STG_G - 4;
    localparam int TAP_W0   = STG_G - 2;
    localparam int TAP_W1   = STG_G;
    localparam int TAP_W2   = STG_G + 2;

    typedef struct packed {
        logic [2:0][15:0] frac;
        logic [2:0][16:0] w;
    } t_fw;

    logic [15:0] r_freq;
    logic [15:0] r_amp;
    logic [TOTAL:1] r_vld;
    logic        s_en;

    logic signed [COORD_WIDTH-1:0] s_coord [3];
    logic signed [LP_W:0]          s_lp    [3];
    logic [LP_W-1:0]               r_lp    [3];
    logic signed [COORD_WIDTH-9:0] s_cell  [3];
    logic [31:0]                   s_cell32 [3];
    logic [2:0][31:0] r_s0;
    logic [2:0][15:0] r_frac2;
    logic [2:0][31:0] r_f2_2;
    logic [2:0][15:0] r_frac3;
    logic [2:0][31:0] r_f2_3;
    logic [2:0][47:0] r_f3;
    logic [31:0]      r_seed [CORNER_COUNT];
    t_fw              n_fw0;
    t_fw              r_fw [FW_LEN];
    logic [50:0]      s_fade [3];

    t_grad_vec        s_grad [CORNER_COUNT];
    logic [2:0][1:0][17:0] s_off;
    logic signed [DOT_W-1:0] r_prod [CORNER_COUNT][3];
    logic signed [DOT_W-1:0] r_dot  [CORNER_COUNT];

    logic signed [52:0] r_l1a [4];
    logic signed [52:0] r_l1b [4];
    logic signed [DOT_W-1:0] r_l1 [4];
    logic signed [52:0] r_l2a [2];
    logic signed [52:0] r_l2b [2];
    logic signed [DOT_W-1:0] r_l2 [2];
    logic signed [52:0] r_l3a;
    logic signed [52:0] r_l3b;
    logic signed [DOT_W-1:0] r_noise;
    logic signed [51:0] r_scaled;
    logic signed [52:0] s_rnd;
    logic signed [52:0] s_shr;
    logic signed [31:0] r_out;

    // pipeline advances unless a finished item is held at the output
    assign s_en        = !(r_vld[TOTAL] && i_stall);
    assign o_stall     = !s_en;
    assign o_valid     = r_vld[TOTAL];
    assign o_noise_sample = r_out;
    assign o_cfg_ready = 1'b1;

    // control registers and valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= FREQ_RESET;
            r_amp  <= AMP_RESET;
            r_vld  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_FREQ: r_freq <= i_cfg_data;
                    REG_AMP:  r_amp  <= i_cfg_data;
                    default:  ;
                endcase
            end
            if (s_en) begin
                r_vld <= {r_vld[TOTAL-1:1], i_valid};
            end
        end
    end

    // coordinate fit to the lattice width
    if (COORD_WIDTH > 32) begin : g_wide
        assign s_coord[0] = {{(COORD_WIDTH-32){1'b0}}, i_coord_x};
        assign s_coord[1] = {{(COORD_WIDTH-32){1'b0}}, i_coord_y};
        assign s_coord[2] = {{(COORD_WIDTH-32){1'b0}}, i_coord_z};
    end else begin : g_narrow
        assign s_coord[0] = i_coord_x[COORD_WIDTH-1:0];
        assign s_coord[1] = i_coord_y[COORD_WIDTH-1:0];
        assign s_coord[2] = i_coord_z[COORD_WIDTH-1:0];
    end

    // lattice position, cell and fraction, fade polynomial
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_lp[i]     = s_coord[i] * $signed({1'b0, r_freq});
            s_cell[i]   = $signed(r_lp[i][LP_W-1:24]);
            s_cell32[i] = 32'(s_cell[i]);
            s_fade[i]   = 51'({r_f2_3[i], 16'b0}) * 51'd3 - 51'(r_f3[i]) * 51'd2
                        + (51'd1 << 31);
            n_fw0.frac[i] = r_frac3[i];
            n_fw0.w[i]    = s_fade[i][48:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            for (int i = 0; i < 3; i++) begin
                r_lp[i]    <= s_lp[i][LP_W-1:0];
                r_frac2[i] <= r_lp[i][23:8];
                r_f2_2[i]  <= r_lp[i][23:8] * r_lp[i][23:8];
                r_frac3[i] <= r_frac2[i];
                r_f2_3[i]  <= r_f2_2[i];
                r_f3[i]    <= r_f2_2[i] * r_frac2[i];
            end
            r_s0[0] <= s_cell32[0] * SEED_MUL_X;
            r_s0[1] <= s_cell32[1] * SEED_MUL_Y;
            r_s0[2] <= s_cell32[2];
            r_fw[0] <= n_fw0;
            for (int k = 1; k < FW_LEN; k++) begin
                r_fw[k] <= r_fw[k-1];
            end
        end
    end

    // corner seeds and gradient lanes
    for (genvar k = 0; k < CORNER_COUNT; k++) begin : g_corner
        always_ff @(posedge i_clk) begin
            if (s_en) begin
                r_seed[k] <= (((k & 1) != 0) ? r_s0[0] + SEED_MUL_X : r_s0[0])
                           + (((k & 2) != 0) ? r_s0[1] + SEED_MUL_Y : r_s0[1])
                           + (((k & 4) != 0) ? r_s0[2] + 32'd1 : r_s0[2]);
            end
        end

        gn3_corner u_corner (
            .i_clk  (i_clk),
            .i_en   (s_en),
            .i_seed (r_seed[k]),
            .o_grad (s_grad[k])
        );
    end

    // corner offsets: fraction, or fraction minus one
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_off[i][0] = {2'b00, r_fw[TAP_FRAC].frac[i]};
            s_off[i][1] = {2'b11, r_fw[TAP_FRAC].frac[i]};
        end
    end

    // gradient dot offset
    for (genvar k = 0; k < CORNER_COUNT; k++) begin : g_dot
        always_ff @(posedge i_clk) begin
            if (s_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_prod[k][i] <= $signed(s_grad[k][i]) * $signed(s_off[i][(k >> i) & 1]);
                end
                r_dot[k] <= r_prod[k][0] + r_prod[k][1] + r_prod[k][2];
            end
        end
    end

    function automatic logic signed [DOT_W-1:0] f_lerp_rnd(
        input logic signed [52:0] pa,
        input logic signed [52:0] pb
    );
        logic signed [53:0] sum;
        sum = 54'(pa) + 54'(pb) + 54'sd32768;
        return sum[DOT_W+15:16];
    endfunction

    // trilinear blend: x, then y, then z
    always_ff @(posedge i_clk) begin
        if (s_en) begin
            for (int k = 0; k < 4; k++) begin
                r_l1a[k] <= r_dot[2*k] * $signed({1'b0, 17'h10000 - r_fw[TAP_W0].w[0]});
                r_l1b[k] <= r_dot[2*k+1] * $signed({1'b0, r_fw[TAP_W0].w[0]});
                r_l1[k]  <= f_lerp_rnd(r_l1a[k], r_l1b[k]);
            end
            for (int k = 0; k < 2; k++) begin
                r_l2a[k] <= r_l1[2*k] * $signed({1'b0, 17'h10000 - r_fw[TAP_W1].w[1]});
                r_l2b[k] <= r_l1[2*k+1] * $signed({1'b0, r_fw[TAP_W1].w[1]});
                r_l2[k]  <= f_lerp_rnd(r_l2a[k], r_l2b[k]);
            end
            r_l3a   <= r_l2[0] * $signed({1'b0, 17'h10000 - r_fw[TAP_W2].w[2]});
            r_l3b   <= r_l2[1] * $signed({1'b0, r_fw[TAP_W2].w[2]});
            r_noise <= f_lerp_rnd(r_l3a, r_l3b);
        end
    end

    // amplitude, rounding and saturation
    always_comb begin
        s_rnd = 53'(r_scaled) + (53'sd1 <<< 28);
        s_shr = s_rnd >>> 29;
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_scaled <= r_noise * $signed({1'b0, r_amp});
            if (s_shr > 53'sd2147483647) begin
                r_out <= 32'sh7fffffff;
            end else if (s_shr < -53'sd2147483648) begin
                r_out <= 32'sh80000000;
            end else begin
                r_out <= s_shr[31:0];
            end
        end
    end

endmodule

[hw/rtl/gn3_checker.sv]
`timescale 1ns / 1ps

module gn3_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic signed [31:0] i_coord_x,
    input logic signed [31:0] i_coord_y,
    input logic signed [31:0] i_coord_z,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_noise_sample,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic [7:0]         i_cfg_index,
    input logic [15:0]        i_cfg_data
);

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_noise_sample))
        else $error("result changed while stalled");

    // input stall only comes from a held result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

    // no back-pressure means items flow in
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && i_stall) |-> !o_stall)
        else $error("input stalled while output free");

    // pipeline empty right after reset
    a_rst: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule

bind gradient_noise_3d_scalar gn3_checker u_gn3_checker (.*);
